// ----- src/ohpc_pkg.sv -----
// shared types, codes and constant tables for the object header checker
package ohpc_pkg;

  // width of the size, header and content counters and of the length fields
  localparam int LEN_BITS = 32;
  // a type name this long or longer never matches
  localparam int MAX_NAME_LENGTH = 16;
  // name position saturates here
  localparam logic [3:0] NAME_POS_MAX = 4'd15;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // parse phases
  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_BAD_TYPE = 3'd2,
    ST_NO_NUL   = 3'd3,
    ST_BAD_SIZE = 3'd4,
    ST_MISMATCH = 3'd5
  } status_t;

  // object type codes
  localparam logic [1:0] TYPE_BLOB   = 2'd0;
  localparam logic [1:0] TYPE_TREE   = 2'd1;
  localparam logic [1:0] TYPE_COMMIT = 2'd2;
  localparam logic [1:0] TYPE_TAG    = 2'd3;

  // type name spelling, zero padded
  localparam logic [7:0] TYPE_TEXT [4][8] = '{
    '{8'h62, 8'h6c, 8'h6f, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00},  // blob
    '{8'h74, 8'h72, 8'h65, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // tree
    '{8'h63, 8'h6f, 8'h6d, 8'h6d, 8'h69, 8'h74, 8'h00, 8'h00},  // commit
    '{8'h74, 8'h61, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // tag
  };
  localparam logic [3:0] TYPE_NAME_BYTES [4] = '{4'd4, 4'd4, 4'd6, 4'd3};

  // one request: a byte of the object image
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // one result per object image
  typedef struct packed {
    logic [2:0]          status;
    logic [1:0]          object_type;
    logic [LEN_BITS-1:0] header_length;
    logic [LEN_BITS-1:0] content_length;
  } out_item_t;

endpackage

// ----- src/ohpc_in_stage.sv -----
// input register stage holding one request byte
module ohpc_in_stage
  import ohpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     held_valid,
  output in_item_t held_item
);

  // free when empty or when the held byte moves on this cycle
  assign in_ready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_data;
    end
  end

endmodule

// ----- src/ohpc_parser.sv -----
// header parse state and per-byte update, result formed on the last byte
module ohpc_parser
  import ohpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  phase_t              phase, phase_next;
  logic [3:0]          name_pos, name_pos_next;
  logic [3:0]          cand, cand_next;
  logic [3:0]          hit;
  logic [LEN_BITS-1:0] size_acc, size_acc_next;
  logic [LEN_BITS-1:0] hdr_cnt, hdr_cnt_next;
  logic [LEN_BITS-1:0] body_cnt, body_cnt_next;
  status_t             err, err_next;
  status_t             status;
  logic [1:0]          kind;
  logic [LEN_BITS+3:0] size_prod;
  logic [LEN_BITS+3:0] size_wide;
  logic                is_digit;

  // state registers, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_NAME;
      name_pos <= '0;
      cand     <= 4'hF;
      size_acc <= '0;
      hdr_cnt  <= '0;
      body_cnt <= '0;
      err      <= ST_OK;
    end else if (step) begin
      if (item.last_byte) begin
        phase    <= PH_NAME;
        name_pos <= '0;
        cand     <= 4'hF;
        size_acc <= '0;
        hdr_cnt  <= '0;
        body_cnt <= '0;
        err      <= ST_OK;
      end else begin
        phase    <= phase_next;
        name_pos <= name_pos_next;
        cand     <= cand_next;
        size_acc <= size_acc_next;
        hdr_cnt  <= hdr_cnt_next;
        body_cnt <= body_cnt_next;
        err      <= err_next;
      end
    end
  end

  // size times ten plus digit, with room to see overflow
  assign size_wide = {4'b0, size_acc};
  assign is_digit  = (item.data_byte >= CHAR_ZERO) && (item.data_byte <= CHAR_NINE);
  assign size_prod = (size_wide << 3) + (size_wide << 1)
                   + {{LEN_BITS{1'b0}}, 4'(item.data_byte - CHAR_ZERO)};

  // next state for one byte
  always_comb begin
    phase_next    = phase;
    name_pos_next = name_pos;
    cand_next     = cand;
    size_acc_next = size_acc;
    hdr_cnt_next  = hdr_cnt;
    body_cnt_next = body_cnt;
    err_next      = err;
    hit           = '0;
    unique case (phase)
      PH_NAME: begin
        hdr_cnt_next = (&hdr_cnt) ? hdr_cnt : hdr_cnt + LEN_BITS'(1);
        if (item.data_byte == CHAR_SPACE) begin
          for (int i = 0; i < 4; i++) begin
            if (cand[i] && (TYPE_NAME_BYTES[i] == name_pos)
                && ({1'b0, name_pos} < 5'(MAX_NAME_LENGTH))) begin
              hit = 4'(1 << i);
            end
          end
          if (hit != '0) begin
            cand_next  = hit;
            phase_next = PH_SIZE;
          end else begin
            err_next   = ST_BAD_TYPE;
            phase_next = PH_FAIL;
          end
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (!((name_pos < TYPE_NAME_BYTES[i])
                  && (TYPE_TEXT[i][name_pos[2:0]] == item.data_byte))) begin
              cand_next[i] = 1'b0;
            end
          end
          if (name_pos != NAME_POS_MAX) begin
            name_pos_next = name_pos + 4'd1;
          end
        end
      end
      PH_SIZE: begin
        hdr_cnt_next = (&hdr_cnt) ? hdr_cnt : hdr_cnt + LEN_BITS'(1);
        if (item.data_byte == CHAR_NUL) begin
          phase_next = (err != ST_OK) ? PH_FAIL : PH_BODY;
        end else if (err == ST_OK) begin
          if (!is_digit || (size_prod[LEN_BITS+3:LEN_BITS] != '0)) begin
            err_next = ST_BAD_SIZE;
          end else begin
            size_acc_next = size_prod[LEN_BITS-1:0];
          end
        end
      end
      PH_BODY: begin
        if (&body_cnt) begin
          err_next = ST_MISMATCH;
        end else begin
          body_cnt_next = body_cnt + LEN_BITS'(1);
        end
      end
      PH_FAIL: begin
      end
      default: begin
      end
    endcase
  end

  // status after this byte
  always_comb begin
    unique case (phase_next)
      PH_NAME: status = ST_NO_SPACE;
      PH_FAIL: status = err_next;
      PH_SIZE: status = ST_NO_NUL;
      PH_BODY: begin
        if ((err_next != ST_OK) || (body_cnt_next != size_acc_next)) begin
          status = ST_MISMATCH;
        end else begin
          status = ST_OK;
        end
      end
      default: status = ST_NO_SPACE;
    endcase
  end

  // matched type: highest live candidate
  always_comb begin
    kind = TYPE_BLOB;
    for (int i = 0; i < 4; i++) begin
      if (cand_next[i]) begin
        kind = 2'(i);
      end
    end
  end

  // result fields, cleared unless ok
  always_comb begin
    result.status = status;
    if (status == ST_OK) begin
      result.object_type    = kind;
      result.header_length  = hdr_cnt_next;
      result.content_length = size_acc_next;
    end else begin
      result.object_type    = TYPE_BLOB;
      result.header_length  = '0;
      result.content_length = '0;
    end
  end

endmodule

// ----- src/ohpc_out_stage.sv -----
// output register holding one finished result
module ohpc_out_stage
  import ohpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t result,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

// ----- src/object_header_parse_check.sv -----
// top level of the object header checker
// Checks an object image that arrives one byte per request, the header being
// "type SP decimal-size NUL" with type blob, tree, commit or tag. One byte is
// taken every cycle; the parse state is updated by combinational logic
// from the input register, and the byte flagged last produces one result in
// the output register, loaded as that byte moves on. The input register keeps
// taking bytes while a result waits; only a last byte that finds the output
// register still full stalls. Status is ok only when the content byte count
// equals the declared size; other fields are zero on any error.
module object_header_parse_check
  import ohpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      held_valid;
  in_item_t  held_item;
  logic      advance;
  out_item_t result;

  // a held byte moves on unless it is last and the result slot is busy
  assign advance = held_valid
                && (!held_item.last_byte || !out_valid || out_ready);

  ohpc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ohpc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .result (result)
  );

  ohpc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && held_item.last_byte),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
